// ----- hdl/u8u16_pkg.sv -----
// Shared types and constants of the UTF-8 to UTF-16 decoder.
`default_nettype none
package u8u16_pkg;

	localparam logic [15:0] REPL_UNIT = 16'hFFFD;
	localparam logic [7:0]  ASCII_MAX = 8'h7F;
	localparam logic [7:0]  LEAD2_MIN = 8'hC2;
	localparam logic [7:0]  LEAD2_MAX = 8'hDF;
	localparam logic [7:0]  LEAD3_MIN = 8'hE0;
	localparam logic [7:0]  LEAD3_MAX = 8'hEF;
	localparam logic [7:0]  LEAD4_MIN = 8'hF0;
	localparam logic [7:0]  LEAD4_MAX = 8'hF4;
	localparam logic [1:0]  CONT_TAG  = 2'b10;
	localparam logic [20:0] MIN3      = 21'h000800;
	localparam logic [20:0] SURR_LO   = 21'h00D800;
	localparam logic [20:0] SURR_HI   = 21'h00DFFF;
	localparam logic [20:0] MIN4      = 21'h010000;
	localparam logic [20:0] MAX4      = 21'h10FFFF;
	localparam logic [15:0] HI_BASE   = 16'hD800;
	localparam logic [15:0] LO_BASE   = 16'hDC00;

	localparam int QUEUE_DEPTH = 3;
	localparam int HELD_DEPTH  = 3;

	localparam logic [2:0] LEN2 = 3'd2;
	localparam logic [2:0] LEN3 = 3'd3;
	localparam logic [2:0] LEN4 = 3'd4;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_valid;
		logic        is_replacement;
		logic        chunk_done;
		logic        chunk_incomplete;
		logic        chunk_had_invalid;
		logic        last_of_run;
	} item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic low;
		logic status;
		logic flush;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pend_v;
		logic out_space;
		logic pair;
		logic drained_after_step;
		logic queue_empty;
		logic end_of_chunk;
	} sts_t;

endpackage
`default_nettype wire

// ----- hdl/u8u16_dpath.sv -----
// Datapath of the UTF-8 to UTF-16 decoder: byte queue, sequence state and result registers.
`default_nettype none
module u8u16_dpath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire u8u16_pkg::cmd_t cmd,
	output u8u16_pkg::sts_t      sts,
	input  wire logic [7:0]      in_byte,
	input  wire logic            in_end,
	output u8u16_pkg::item_t     out_item,
	output logic                 out_valid,
	input  wire logic            out_ready
);
	import u8u16_pkg::*;

	logic [7:0]  q_q [QUEUE_DEPTH];
	logic [1:0]  q_cnt_q;
	logic        end_q;
	logic [7:0]  held_q [HELD_DEPTH];
	logic [1:0]  held_cnt_q;
	logic [2:0]  seq_len_q;
	logic [20:0] part_q;
	logic        saw_q;
	logic [15:0] low_q;
	item_t       pend_q;
	logic        pend_v_q;
	item_t       out_q;
	logic        out_v_q;

	logic [7:0]  b;
	logic [7:0]  nx_held [HELD_DEPTH];
	logic [1:0]  nx_hcnt;
	logic [2:0]  nx_slen;
	logic [20:0] nx_part;
	logic        nx_saw;
	item_t       st_item;
	logic        st_has;
	logic        st_pair;
	logic [15:0] st_low;
	logic        replay;
	logic [7:0]  rp [QUEUE_DEPTH];
	logic [7:0]  nx_q [QUEUE_DEPTH];
	logic [2:0]  nx_qcnt_w;
	logic [2:0]  sel;
	logic [20:0] cp;
	logic [19:0] v;
	logic        cont_ok;
	logic        range_ok;
	logic        gen;
	logic        push;
	logic        out_space;
	item_t       new_item;
	item_t       nx_out;

	assign b         = q_q[0];
	assign cp        = {part_q[14:0], b[5:0]};
	assign v         = 20'(cp - MIN4);
	assign out_space = !out_v_q || out_ready;

	// One decode step on the byte at the head of the queue.
	always_comb begin
		nx_held  = held_q;
		nx_hcnt  = held_cnt_q;
		nx_slen  = seq_len_q;
		nx_part  = part_q;
		nx_saw   = saw_q;
		st_item  = '0;
		st_has   = 1'b0;
		st_pair  = 1'b0;
		st_low   = LO_BASE + {6'd0, v[9:0]};
		replay   = 1'b0;
		cont_ok  = (b[7:6] == CONT_TAG)
			&& (held_cnt_q < 2'd2 || held_q[1][7:6] == CONT_TAG)
			&& (held_cnt_q < 2'd3 || held_q[2][7:6] == CONT_TAG);
		range_ok = 1'b1;
		if (held_cnt_q == 2'd2) begin
			range_ok = cp >= MIN3 && !(cp >= SURR_LO && cp <= SURR_HI);
		end else if (held_cnt_q == 2'd3) begin
			range_ok = cp >= MIN4 && cp <= MAX4;
		end
		if (seq_len_q == 3'd0) begin
			if (b <= ASCII_MAX) begin
				st_has             = 1'b1;
				st_item.code_unit  = {8'd0, b};
				st_item.unit_valid = 1'b1;
			end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
				nx_held[0] = b;
				nx_hcnt    = 2'd1;
				nx_slen    = LEN2;
				nx_part    = {16'd0, b[4:0]};
			end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
				nx_held[0] = b;
				nx_hcnt    = 2'd1;
				nx_slen    = LEN3;
				nx_part    = {17'd0, b[3:0]};
			end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
				nx_held[0] = b;
				nx_hcnt    = 2'd1;
				nx_slen    = LEN4;
				nx_part    = {18'd0, b[2:0]};
			end else begin
				st_has                 = 1'b1;
				st_item.code_unit      = REPL_UNIT;
				st_item.unit_valid     = 1'b1;
				st_item.is_replacement = 1'b1;
				nx_saw                 = 1'b1;
			end
		end else if ({1'b0, held_cnt_q} + 3'd1 < seq_len_q) begin
			for (int i = 0; i < HELD_DEPTH; i++) begin
				if (held_cnt_q == 2'(i)) begin
					nx_held[i] = b;
				end
			end
			nx_hcnt = held_cnt_q + 2'd1;
			nx_part = cp;
		end else begin
			nx_hcnt = 2'd0;
			nx_slen = 3'd0;
			nx_part = '0;
			st_has  = 1'b1;
			st_item.unit_valid = 1'b1;
			if (cont_ok && range_ok) begin
				if (cp[20:16] != 5'd0) begin
					st_pair           = 1'b1;
					st_item.code_unit = HI_BASE + {6'd0, v[19:10]};
				end else begin
					st_item.code_unit = cp[15:0];
				end
			end else begin
				st_item.code_unit      = REPL_UNIT;
				st_item.is_replacement = 1'b1;
				nx_saw                 = 1'b1;
				replay                 = 1'b1;
			end
		end
	end

	// Next queue: the bytes after a rejected lead go back in front of the queue.
	always_comb begin
		rp[0] = b;
		rp[1] = b;
		rp[2] = b;
		case (held_cnt_q)
			2'd2: begin
				rp[0] = held_q[1];
			end
			2'd3: begin
				rp[0] = held_q[1];
				rp[1] = held_q[2];
			end
			default: begin
				rp[0] = b;
			end
		endcase
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			nx_q[i] = q_q[i];
		end
		sel = 3'd0;
		if (replay) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				sel = 3'(i + 1) - {1'b0, held_cnt_q};
				if (3'(i) < {1'b0, held_cnt_q}) begin
					nx_q[i] = rp[i];
				end else if (sel < 3'(QUEUE_DEPTH)) begin
					nx_q[i] = q_q[sel[1:0]];
				end
			end
			nx_qcnt_w = {1'b0, q_cnt_q} - 3'd1 + {1'b0, held_cnt_q};
		end else begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				nx_q[i] = q_q[i + 1];
			end
			nx_qcnt_w = {1'b0, q_cnt_q} - 3'd1;
		end
	end

	always_comb begin
		new_item = st_item;
		if (cmd.low) begin
			new_item            = '0;
			new_item.code_unit  = low_q;
			new_item.unit_valid = 1'b1;
		end else if (cmd.status) begin
			new_item                   = '0;
			new_item.chunk_done        = 1'b1;
			new_item.chunk_incomplete  = seq_len_q != 3'd0;
			new_item.chunk_had_invalid = saw_q;
		end
	end

	// The word still pending when the controller goes idle closes its byte's run.
	always_comb begin
		nx_out             = pend_q;
		nx_out.last_of_run = cmd.flush;
	end

	assign gen  = (cmd.step && st_has) || cmd.low || cmd.status;
	assign push = gen && pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q    <= '0;
			end_q      <= 1'b0;
			held_cnt_q <= '0;
			seq_len_q  <= '0;
			part_q     <= '0;
			saw_q      <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				q_cnt_q <= 2'd1;
				end_q   <= in_end;
			end else if (cmd.step) begin
				q_cnt_q <= nx_qcnt_w[1:0];
			end
			if (cmd.step) begin
				held_cnt_q <= nx_hcnt;
				seq_len_q  <= nx_slen;
				part_q     <= nx_part;
				saw_q      <= nx_saw;
			end else if (cmd.status) begin
				held_cnt_q <= '0;
				seq_len_q  <= '0;
				part_q     <= '0;
				saw_q      <= 1'b0;
			end
			if (gen) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (push || cmd.flush) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q[0] <= in_byte;
		end else if (cmd.step) begin
			q_q <= nx_q;
		end
		if (cmd.step) begin
			held_q <= nx_held;
			if (st_pair) begin
				low_q <= st_low;
			end
		end
		if (gen) begin
			pend_q <= new_item;
		end
		if (push || cmd.flush) begin
			out_q <= nx_out;
		end
	end

	assign out_item = out_q;
	assign out_valid = out_v_q;

	always_comb begin
		sts.pend_v             = pend_v_q;
		sts.out_space          = out_space;
		sts.pair               = st_pair;
		sts.drained_after_step = nx_qcnt_w == 3'd0;
		sts.queue_empty        = q_cnt_q == 2'd0;
		sts.end_of_chunk       = end_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		seq_len_q == 3'd0 ? held_cnt_q == 2'd0 : held_cnt_q < seq_len_q[1:0] + 2'd0
			|| seq_len_q == LEN4)
		else $error("held byte count out of step with sequence length");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> out_space)
		else $error("pending word pushed into a full output register");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load |-> q_cnt_q == 2'd0)
		else $error("new byte loaded while the replay queue is not empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.status |=> seq_len_q == 3'd0 && !saw_q)
		else $error("chunk state not cleared after the status word");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.step |-> q_cnt_q != 2'd0)
		else $error("decode step with an empty queue");

endmodule
`default_nettype wire

// ----- hdl/u8u16_ctrl.sv -----
// Controller of the UTF-8 to UTF-16 decoder: sequences accept, decode, surrogate and status steps.
`default_nettype none
module u8u16_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire u8u16_pkg::sts_t sts,
	output u8u16_pkg::cmd_t      cmd
);
	import u8u16_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_LOW,
		ST_STATUS
	} state_t;

	state_t state_q;
	logic   can_go;

	// A new result may be produced when the pending slot is free or can move on.
	assign can_go = !sts.pend_v || sts.out_space;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = can_go;
				cmd.flush = sts.pend_v && sts.out_space;
				cmd.load  = in_valid && can_go;
			end
			ST_RUN: begin
				cmd.step = can_go;
			end
			ST_LOW: begin
				cmd.low = can_go;
			end
			ST_STATUS: begin
				cmd.status = can_go;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && can_go) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (can_go) begin
						if (sts.pair) begin
							state_q <= ST_LOW;
						end else if (sts.drained_after_step) begin
							state_q <= sts.end_of_chunk ? ST_STATUS : ST_IDLE;
						end
					end
				end
				ST_LOW: begin
					if (can_go) begin
						if (sts.queue_empty) begin
							state_q <= sts.end_of_chunk ? ST_STATUS : ST_IDLE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_STATUS: begin
					if (can_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/utf8_to_utf16_decoder_top.sv -----
// Top level of the UTF-8 to UTF-16 decoder: controller and datapath.
//
// Channel  Dir  Fields
// s_*      in   tdata[7:0] = in_byte, tlast = chunk_end
// m_*      out  tdata[15:0] = code_unit, tuser[4:0] = flags, tlast = last_of_run
//
// A byte is accepted in the idle state and then decoded in the run state, one decode
// step for each byte in the replay queue; a surrogate pair adds a low-surrogate step and
// the chunk status word a status step. After an invalid sequence each replayed byte adds
// a decode step of its own. The single decode step handles one queued byte per cycle
// while the output does not stall.
// Reset clears all control state; held sequence bytes are left as they are.
// A stalled output holds the decoder once one further word is pending behind it.
`default_nettype none
module utf8_to_utf16_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] code_unit
	output logic [4:0]       m_tuser,   // [0] unit_valid, [1] is_replacement, [2] chunk_done,
	                                    // [3] chunk_incomplete, [4] chunk_had_invalid
	output logic             m_tlast
);
	import u8u16_pkg::*;

	cmd_t  cmd;
	sts_t  sts;
	item_t out_item;

	u8u16_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	u8u16_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_byte   (s_tdata),
		.in_end    (s_tlast),
		.out_item  (out_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	assign m_tdata = out_item.code_unit;
	assign m_tuser = {out_item.chunk_had_invalid, out_item.chunk_incomplete,
		out_item.chunk_done, out_item.is_replacement, out_item.unit_valid};
	assign m_tlast = out_item.last_of_run;

endmodule
`default_nettype wire

// ----- dv/utf8_stream_checker.sv -----
`timescale 1ns / 1ps
// Checker for the UTF-8 to UTF-16 decoder: watches both streams and compares result words.
module utf8_stream_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,   // [15:0] code_unit
	input  wire logic [4:0]  m_tuser,   // [0] unit_valid, [1] is_replacement, [2] chunk_done,
	                                    // [3] chunk_incomplete, [4] chunk_had_invalid
	input  wire logic        m_tlast,
	output int               fail_count,
	output int               due_count,
	output int               bytes_seen,
	output int               words_seen,
	output int               repl_seen,
	output int               chunks_seen,
	output int               cut_chunks
);
	import u8u16_pkg::*;

	localparam int MAX_RUN    = 5;
	localparam int REPLAY_CAP = 8;

	// Decoder state as the predictor sees it.
	logic [7:0]  held [HELD_DEPTH];
	logic [1:0]  held_cnt;
	logic [2:0]  seq_len;
	logic [20:0] partial;
	logic        bad_seen;

	item_t words_due [$];
	item_t run_words [$];

	function automatic void note_word(input logic [15:0] unit, input logic valid,
			input logic repl, input logic done, input logic cut, input logic had);
		item_t w;
		w.code_unit         = unit;
		w.unit_valid        = valid;
		w.is_replacement    = repl;
		w.chunk_done        = done;
		w.chunk_incomplete  = cut;
		w.chunk_had_invalid = had;
		w.last_of_run       = 1'b0;
		if (run_words.size() < MAX_RUN)
			run_words = {run_words, w};
	endfunction

	function automatic void note_replacement();
		bad_seen = 1'b1;
		note_word(REPL_UNIT, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
	endfunction

	function automatic void start_seq(input logic [7:0] lead, input logic [2:0] len,
			input logic [20:0] bits);
		held[0]  = lead;
		held_cnt = 2'd1;
		seq_len  = len;
		partial  = bits;
	endfunction

	// Works out every result word that one accepted byte causes, replays included.
	function automatic void decode_byte(input logic [7:0] in_byte, input logic chunk_end);
		logic [7:0]  pend [$];
		logic [7:0]  b;
		logic [7:0]  seq [4];
		logic [20:0] cp;
		logic [20:0] diff;
		int          len;
		logic        ok;
		run_words.delete();
		pend = {pend, in_byte};
		while (pend.size() > 0) begin
			b = pend.pop_front();
			if (seq_len == 3'd0) begin
				if (b <= ASCII_MAX)
					note_word({8'h00, b}, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
				else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
					start_seq(b, LEN2, {16'h0, b[4:0]});
				else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
					start_seq(b, LEN3, {17'h0, b[3:0]});
				else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
					start_seq(b, LEN4, {18'h0, b[2:0]});
				else
					note_replacement();
			end else if (int'(held_cnt) + 1 < int'(seq_len) && held_cnt < 2'd3) begin
				held[held_cnt] = b;
				held_cnt = held_cnt + 2'd1;
				partial = {partial[14:0], b[5:0]};
			end else begin
				len = int'(held_cnt);
				for (int i = 0; i < len; i++)
					seq[i] = held[i];
				seq[len] = b;
				len++;
				ok = 1'b1;
				for (int i = 1; i < len; i++)
					if (seq[i][7:6] != CONT_TAG)
						ok = 1'b0;
				cp = {partial[14:0], b[5:0]};
				if (ok && len == 3)
					ok = cp >= MIN3 && !(cp >= SURR_LO && cp <= SURR_HI);
				else if (ok && len == 4)
					ok = cp >= MIN4 && cp <= MAX4;
				held_cnt = 2'd0;
				seq_len  = 3'd0;
				partial  = 21'h0;
				if (ok) begin
					if (cp < MIN4) begin
						note_word(cp[15:0], 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
					end else begin
						diff = cp - MIN4;
						note_word(HI_BASE + 16'(diff[19:10]), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
						note_word(LO_BASE + 16'(diff[9:0]), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
					end
				end else begin
					// Only the lead is consumed; the rest goes back to the front in order.
					note_replacement();
					if (pend.size() + len - 1 <= REPLAY_CAP)
						for (int i = len - 1; i >= 1; i--)
							pend.push_front(seq[i]);
				end
			end
		end
		if (chunk_end) begin
			note_word(16'h0000, 1'b0, 1'b0, 1'b1, seq_len != 3'd0, bad_seen);
			held_cnt = 2'd0;
			seq_len  = 3'd0;
			partial  = 21'h0;
			bad_seen = 1'b0;
		end
		if (run_words.size() > 0)
			run_words[run_words.size() - 1].last_of_run = 1'b1;
		foreach (run_words[i]) begin
			words_due = {words_due, run_words[i]};
			words_seen++;
			if (run_words[i].is_replacement)
				repl_seen++;
			if (run_words[i].chunk_done)
				chunks_seen++;
			if (run_words[i].chunk_incomplete)
				cut_chunks++;
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %h, got %h", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t want;
		if (!arst_n) begin
			held_cnt = 2'd0;
			seq_len  = 3'd0;
			partial  = 21'h0;
			bad_seen = 1'b0;
			words_due.delete();
			fail_count  = 0;
			bytes_seen  = 0;
			words_seen  = 0;
			repl_seen   = 0;
			chunks_seen = 0;
			cut_chunks  = 0;
		end else begin
			// A result word never leaves in the cycle its byte is taken, so the
			// prediction can be queued first.
			if (s_tvalid && s_tready) begin
				bytes_seen++;
				decode_byte(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (words_due.size() == 0) begin
					$error("unexpected result word: code_unit %h, flags %b, last %b",
						m_tdata, m_tuser, m_tlast);
					fail_count++;
				end else begin
					want = words_due.pop_front();
					check_field("code_unit", want.code_unit, m_tdata);
					check_field("unit_valid", 16'(want.unit_valid), 16'(m_tuser[0]));
					check_field("is_replacement", 16'(want.is_replacement),
						16'(m_tuser[1]));
					check_field("chunk_done", 16'(want.chunk_done), 16'(m_tuser[2]));
					check_field("chunk_incomplete", 16'(want.chunk_incomplete),
						16'(m_tuser[3]));
					check_field("chunk_had_invalid", 16'(want.chunk_had_invalid),
						16'(m_tuser[4]));
					check_field("last_of_run", 16'(want.last_of_run), 16'(m_tlast));
				end
			end
		end
		due_count = words_due.size();
	end

endmodule

// ----- dv/tb_utf8_to_utf16_decoder_top.sv -----
`timescale 1ns / 1ps
// Testbench top of the UTF-8 to UTF-16 decoder: clock, reset, stimulus, pacing and verdict.
module tb_utf8_to_utf16_decoder_top;
	import u8u16_pkg::*;

	localparam int RANDOM_BYTES = 133;
	localparam int IDLE_PCT     = 16;
	localparam int HOLD_CYCLES  = 250;
	localparam int DRAIN_CYCLES = 20;
	localparam int DIR_COUNT    = 27;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;

	int fail_count, due_count, bytes_seen, words_seen, repl_seen, chunks_seen, cut_chunks;

	int sent        = 0;
	bit tx_steady   = 1'b0;
	bit rx_steady   = 1'b0;
	int hold_reqs   = 0;
	int hold_served = 0;
	int hold_left   = 0;

	logic [7:0] chunk_q [$];

	// Bit 8 marks the last byte of a chunk.
	logic [8:0] directed [DIR_COUNT] = '{
		9'h000, 9'h07F, 9'h0C2, 9'h080,             // ASCII bounds, smallest two-byte
		9'h0E0, 9'h0A0, 9'h080,                     // smallest three-byte
		9'h0ED, 9'h0A0, 9'h080,                     // surrogate, replayed
		9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,             // largest point as a pair, chunk closes
		9'h0F0, 9'h0E0, 9'h080, 9'h141,             // nested bad sequences, five words
		9'h0F4, 9'h090, 9'h080, 9'h080,             // beyond the top of the range
		9'h0C1, 9'h0DF, 9'h0BF,                     // bad lead, largest two-byte
		9'h0E0, 9'h19F                              // chunk ends inside a sequence
	};

	utf8_to_utf16_decoder_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	utf8_stream_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.due_count   (due_count),
		.bytes_seen  (bytes_seen),
		.words_seen  (words_seen),
		.repl_seen   (repl_seen),
		.chunks_seen (chunks_seen),
		.cut_chunks  (cut_chunks)
	);

	always #2 clk = ~clk;

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

	// Output side: random back-pressure, a quiet stretch, and one long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_reqs != hold_served) begin
			hold_served++;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (rx_steady) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send_word(input logic [7:0] b, input logic last);
		@(negedge clk);
		while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	function automatic void add_byte(input logic [7:0] b);
		chunk_q = {chunk_q, b};
	endfunction

	function automatic void push_cont();
		add_byte(8'(8'h80 | $urandom_range(63)));
	endfunction

	function automatic void push_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			add_byte(cp[7:0]);
		end else if (cp < MIN3) begin
			add_byte({3'b110, cp[10:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (cp < MIN4) begin
			add_byte({4'b1110, cp[15:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end else begin
			add_byte({5'b11110, cp[20:18]});
			add_byte({2'b10, cp[17:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end
	endfunction

	// A point that needs two to four bytes, never a surrogate.
	function automatic logic [20:0] wide_point();
		logic [20:0] cp;
		case ($urandom_range(2, 4))
			2: cp = 21'($urandom_range(32'h80, 32'h7FF));
			3: begin
				cp = 21'($urandom_range(32'h800, 32'hFFFF));
				if (cp >= SURR_LO && cp <= SURR_HI)
					cp = cp - 21'h1000;
			end
			default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
		endcase
		return cp;
	endfunction

	// Sequences whose continuations are well formed but whose value is not allowed, or a lead byte that is never allowed.
	function automatic void push_ill_formed();
		case ($urandom_range(4))
			0: begin
				add_byte(LEAD3_MIN);
				add_byte(8'(8'h80 | $urandom_range(31)));
				push_cont();
			end
			1: begin
				add_byte(8'hED);
				add_byte(8'(8'hA0 | $urandom_range(31)));
				push_cont();
			end
			2: begin
				add_byte(LEAD4_MIN);
				add_byte(8'(8'h80 | $urandom_range(15)));
				push_cont();
				push_cont();
			end
			3: begin
				add_byte(LEAD4_MAX);
				add_byte(8'(8'h90 + $urandom_range(47)));
				push_cont();
				push_cont();
			end
			default: begin
				if ($urandom_range(1))
					add_byte(8'($urandom_range(32'hC0, 32'hC1)));
				else
					add_byte(8'($urandom_range(32'hF5, 32'hFF)));
			end
		endcase
	endfunction

	// Mostly well-formed text with random content, mixed with noise and broken sequences.
	task automatic build_chunk();
		int          segs;
		int          r;
		int          base;
		int          pos;
		logic [20:0] cp;
		logic [7:0]  b;
		chunk_q.delete();
		segs = $urandom_range(1, 6);
		repeat (segs) begin
			r = $urandom_range(99);
			if (r < 18) begin
				push_point(21'($urandom_range(32'h7F)));
			end else if (r < 64) begin
				cp = wide_point();
				push_point(cp);
			end else if (r < 72) begin
				add_byte(8'($urandom_range(255)));
			end else if (r < 80) begin
				base = chunk_q.size();
				push_point(wide_point());
				pos = $urandom_range(base + 1, chunk_q.size() - 1);
				b = 8'($urandom_range(255));
				if (b[7:6] == CONT_TAG)
					b[7] = 1'b0;
				chunk_q[pos] = b;
			end else if (r < 90) begin
				push_ill_formed();
			end else begin
				base = chunk_q.size();
				push_point(wide_point());
				repeat ($urandom_range(1, chunk_q.size() - base - 1))
					void'(chunk_q.pop_back());
			end
		end
	endtask

	initial begin
		bit paused;
		paused = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (directed[i])
			send_word(directed[i][7:0], directed[i][8]);

		while (sent < DIR_COUNT + RANDOM_BYTES) begin
			build_chunk();
			tx_steady = sent >= DIR_COUNT + 70 && sent < DIR_COUNT + 110;
			rx_steady = tx_steady;
			// The long output hold-off starts while bytes keep coming.
			if (hold_reqs == 0 && sent >= DIR_COUNT + 30)
				hold_reqs++;
			foreach (chunk_q[j])
				send_word(chunk_q[j], j == chunk_q.size() - 1);
			if (!paused && sent >= DIR_COUNT + 120) begin
				paused = 1'b1;
				@(negedge clk) s_tvalid <= 1'b0;
				wait (due_count == 0);
			end
		end

		@(negedge clk) s_tvalid <= 1'b0;
		wait (due_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d bytes in %0d chunks, %0d of them cut short inside a sequence",
			bytes_seen, chunks_seen, cut_chunks);
		$display("summary: %0d result words checked, %0d replacement units",
			words_seen, repl_seen);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/u8u16_pkg.sv
hdl/u8u16_dpath.sv
hdl/u8u16_ctrl.sv
hdl/utf8_to_utf16_decoder_top.sv
dv/utf8_stream_checker.sv
dv/tb_utf8_to_utf16_decoder_top.sv
